// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked outside reset.
`define TESP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define TESP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TESP_ASSERT(lbl, prop, msg)
`define TESP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hdl/tesp_pkg.sv =====
package tesp_pkg;

    // parser modes
    localparam logic [2:0] MODE_TEXT    = 3'd0;
    localparam logic [2:0] MODE_ESC     = 3'd1;
    localparam logic [2:0] MODE_CSI     = 3'd2;
    localparam logic [2:0] MODE_STR     = 3'd3;
    localparam logic [2:0] MODE_STR_BEL = 3'd4;
    localparam logic [2:0] MODE_STR_ESC = 3'd5;
    localparam logic [2:0] MODE_STR_C2  = 3'd6;

    // sequence types
    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_CSI  = 3'd1;
    localparam logic [2:0] SEQ_OSC  = 3'd2;
    localparam logic [2:0] SEQ_DCS  = 3'd3;
    localparam logic [2:0] SEQ_PM   = 3'd4;
    localparam logic [2:0] SEQ_SOS  = 3'd5;
    localparam logic [2:0] SEQ_APC  = 3'd6;

    // result kinds
    localparam logic [1:0] KIND_TEXT      = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD   = 2'd1;
    localparam logic [1:0] KIND_END       = 2'd2;
    localparam logic [1:0] KIND_MALFORMED = 2'd3;

    // UTF-8 decoder states of note
    localparam logic [3:0] U8_ACCEPT = 4'd0;
    localparam logic [3:0] U8_REJECT = 4'd1;
    localparam logic [3:0] U8_STATES = 4'd9;

    // special bytes
    localparam logic [7:0] B_BEL     = 8'h07;
    localparam logic [7:0] B_ESC     = 8'h1B;
    localparam logic [7:0] B_DASH    = 8'h2D;
    localparam logic [7:0] B_BSLASH  = 8'h5C;
    localparam logic [7:0] B_ESC_DCS = 8'h50;
    localparam logic [7:0] B_ESC_CSI = 8'h5B;
    localparam logic [7:0] B_ESC_OSC = 8'h5D;
    localparam logic [7:0] B_ESC_PM  = 8'h5E;
    localparam logic [7:0] B_ESC_APC = 8'h5F;
    localparam logic [7:0] B_C2      = 8'hC2;
    localparam logic [7:0] B_C1_ST   = 8'h9C;

    // ESC and C1 introducers as decoded codepoints
    localparam logic [20:0] CP_ESC = 21'h1B;
    localparam logic [20:0] CP_DCS = 21'h90;
    localparam logic [20:0] CP_SOS = 21'h98;
    localparam logic [20:0] CP_CSI = 21'h9B;
    localparam logic [20:0] CP_OSC = 21'h9D;
    localparam logic [20:0] CP_PM  = 21'h9E;
    localparam logic [20:0] CP_APC = 21'h9F;

    localparam int QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [20:0] value;
        logic [2:0]  seq_type;
    } res_t;

    // results of one input byte
    typedef struct packed {
        res_t r0;
        res_t r1;
        logic two;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic [3:0]  st;
        logic [20:0] acc;
    } u8_res_t;

    localparam logic [3:0] U8_NEXT [0:8][0:11] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1, 4'd1, 4'd1, 4'd4, 4'd6},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1},
        '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
        '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
        '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}
    };

    function automatic logic [3:0] byte_class(input logic [7:0] b);
        logic [3:0] c;
        if (b < 8'h80)       c = 4'd0;
        else if (b < 8'h90)  c = 4'd1;
        else if (b < 8'hA0)  c = 4'd9;
        else if (b < 8'hC0)  c = 4'd7;
        else if (b < 8'hC2)  c = 4'd8;
        else if (b < 8'hE0)  c = 4'd2;
        else if (b == 8'hE0) c = 4'd10;
        else if (b == 8'hED) c = 4'd4;
        else if (b < 8'hF0)  c = 4'd3;
        else if (b == 8'hF0) c = 4'd11;
        else if (b < 8'hF4)  c = 4'd6;
        else if (b == 8'hF4) c = 4'd5;
        else                 c = 4'd8;
        return c;
    endfunction

    // one decoder step; out-of-range states behave as reject
    function automatic u8_res_t u8_step(input logic [3:0] st_in, input logic [20:0] acc,
                                        input logic [7:0] b);
        u8_res_t    r;
        logic [3:0] cls;
        logic [3:0] st;
        logic [7:0] lead_mask;
        cls = byte_class(b);
        st  = (st_in < U8_STATES) ? st_in : U8_REJECT;
        lead_mask = 8'hFF >> cls;
        if (st == U8_ACCEPT)
            r.acc = {13'd0, lead_mask & b};
        else
            r.acc = {acc[14:0], b[5:0]};
        r.st = U8_NEXT[st][cls];
        return r;
    endfunction

endpackage

// ===== hdl/tesp_byte_if.sv =====
interface tesp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink (input valid, input byte_in, output ready);
endinterface

// ===== hdl/tesp_res_if.sv =====
interface tesp_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [20:0] value;
    logic [2:0]  seq_type;
    logic        last;

    modport source (output valid, output kind, output value, output seq_type, output last,
                    input ready);
    modport sink (input valid, input kind, input value, input seq_type, input last,
                  output ready);
endinterface

// ===== hdl/terminal_escape_sequence_parser_top.sv =====
// Channel   Dir  Payload                         Transfer
// byte_ch   in   byte_in[7:0]                    valid & ready
// res_ch    out  kind, value, seq_type, last     valid & ready
//
// One byte per cycle accepted while the queue has room; its results pass through
// the result queue and then the output register before they show on res_ch.
// A byte with two results issues them one after the other; the result queue
// (QUEUE_DEPTH entries) absorbs these, byte_ch.ready drops only when it fills.
// Reset (rst_n low, async) returns the parser to text mode and empties queue
// and output register; no clearing pass is needed.
// Stalls on res_ch back up into the queue; neither side waits on the other
// while the queue has room and data.
`include "assert_macros.svh"

module terminal_escape_sequence_parser_top #(
    parameter int QUEUE_DEPTH = tesp_pkg::QUEUE_DEPTH_DEF
) (
    input logic        clk,
    input logic        rst_n,
    tesp_byte_if.sink  byte_ch,
    tesp_res_if.source res_ch
);

    // Front end: parser state, UTF-8 decode, sequence framing.  Each
    // transferred byte yields zero, one or two results packed in one entry.
    tesp_pkg::q_status_t q_stat;
    logic                push;
    tesp_pkg::entry_t    push_data;
    logic                pop;
    tesp_pkg::entry_t    pop_data;

    tesp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (byte_ch),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    // Entry queue decoupling parse from issue.
    tesp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    // Back end: one result per cycle into the output register unless res_ch stalls, last set on
    // the final result of each byte.
    tesp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .pop_data (pop_data),
        .pop      (pop),
        .res_ch   (res_ch)
    );

    // Output register is empty while reset is held.
    `TESP_ASSERT_ALWAYS(a_rst_empty, !rst_n |-> !res_ch.valid, "output valid in reset")
    // Second result of a byte follows right after the first.
    `TESP_ASSERT(a_pair, res_ch.valid && res_ch.ready && !res_ch.last |=> res_ch.valid, "pair split")
    // Queued work reaches an idle output register next cycle.
    `TESP_ASSERT(a_issue, (!q_stat.empty && !res_ch.valid) |=> res_ch.valid, "entry not issued")

endmodule

// ===== hdl/tesp_front.sv =====
// Byte classifier: holds parser state, turns each byte into 0..2 results.
module tesp_front (
    input  logic                clk,
    input  logic                rst_n,
    tesp_byte_if.sink           byte_ch,
    input  tesp_pkg::q_status_t q_stat,
    output logic                push,
    output tesp_pkg::entry_t    push_data
);

    logic [2:0]  mode_reg, mode_next;
    logic [2:0]  seq_reg, seq_next;
    logic        phase_reg, phase_next;
    logic [3:0]  u8_reg, u8_next;
    logic [20:0] acc_reg, acc_next;

    logic [7:0]  b;
    logic        take;
    logic [1:0]  cnt;
    tesp_pkg::res_t r0, r1;

    // text decode path
    logic [3:0]  tx_st0;
    logic [20:0] tx_acc0;
    tesp_pkg::u8_res_t s1, s2;
    logic [3:0]  tx_st;
    logic [20:0] tx_acc;

    // CSI byte classes
    logic is_param, is_fin, is_inter;

    assign b    = byte_ch.byte_in;
    assign byte_ch.ready = !q_stat.full;
    assign take = byte_ch.valid && !q_stat.full;

    assign tx_st0  = (mode_reg == tesp_pkg::MODE_ESC) ? tesp_pkg::U8_ACCEPT : u8_reg;
    assign tx_acc0 = (mode_reg == tesp_pkg::MODE_ESC) ? 21'd0 : acc_reg;
    assign s1 = tesp_pkg::u8_step(tx_st0, tx_acc0, b);
    assign s2 = tesp_pkg::u8_step(tesp_pkg::U8_ACCEPT, 21'd0, b);

    // reject returns to accept; a partial sequence gets the byte decoded again
    always_comb
    begin
        tx_st  = s1.st;
        tx_acc = s1.acc;
        if (s1.st == tesp_pkg::U8_REJECT)
        begin
            if (tx_st0 != tesp_pkg::U8_ACCEPT && s2.st != tesp_pkg::U8_REJECT)
            begin
                tx_st  = s2.st;
                tx_acc = s2.acc;
            end
            else
            begin
                tx_st  = tesp_pkg::U8_ACCEPT;
                tx_acc = 21'd0;
            end
        end
    end

    assign is_param = (b >= 8'h30 && b <= 8'h3F) || b == tesp_pkg::B_DASH;
    assign is_fin   = !is_param && b >= 8'h40 && b <= 8'h7E;
    assign is_inter = !is_param && b >= 8'h20 && b <= 8'h2F;

    always_comb
    begin
        mode_next  = mode_reg;
        seq_next   = seq_reg;
        phase_next = phase_reg;
        u8_next    = u8_reg;
        acc_next   = acc_reg;
        cnt        = 2'd0;
        r0 = '{kind: tesp_pkg::KIND_PAYLOAD, value: {13'd0, b}, seq_type: seq_reg};
        r1 = '{kind: tesp_pkg::KIND_MALFORMED, value: 21'd0, seq_type: seq_reg};
        case (mode_reg)
            tesp_pkg::MODE_CSI:
            begin
                cnt = 2'd1;
                if (is_fin)
                begin
                    r1.kind    = tesp_pkg::KIND_END;
                    cnt        = 2'd2;
                    mode_next  = tesp_pkg::MODE_TEXT;
                    seq_next   = tesp_pkg::SEQ_NONE;
                    phase_next = 1'b0;
                    u8_next    = tesp_pkg::U8_ACCEPT;
                    acc_next   = 21'd0;
                end
                else if (!phase_reg)
                begin
                    if (is_inter)
                        phase_next = 1'b1;
                    else if (!is_param)
                        cnt = 2'd2;
                end
                else if (!is_inter)
                begin
                    cnt = 2'd2;
                end
            end
            tesp_pkg::MODE_STR, tesp_pkg::MODE_STR_BEL:
            begin
                if (mode_reg == tesp_pkg::MODE_STR_BEL && b == tesp_pkg::B_BEL)
                begin
                    r0.kind    = tesp_pkg::KIND_END;
                    r0.value   = 21'd0;
                    cnt        = 2'd1;
                    mode_next  = tesp_pkg::MODE_TEXT;
                    seq_next   = tesp_pkg::SEQ_NONE;
                    phase_next = 1'b0;
                    u8_next    = tesp_pkg::U8_ACCEPT;
                    acc_next   = 21'd0;
                end
                else if (b == tesp_pkg::B_ESC)
                    mode_next = tesp_pkg::MODE_STR_ESC;
                else if (b == tesp_pkg::B_C2)
                    mode_next = tesp_pkg::MODE_STR_C2;
                else
                    cnt = 2'd1;
            end
            tesp_pkg::MODE_STR_ESC, tesp_pkg::MODE_STR_C2:
            begin
                if ((mode_reg == tesp_pkg::MODE_STR_ESC && b == tesp_pkg::B_BSLASH) ||
                    (mode_reg == tesp_pkg::MODE_STR_C2 && b == tesp_pkg::B_C1_ST))
                begin
                    r0.kind    = tesp_pkg::KIND_END;
                    r0.value   = 21'd0;
                    cnt        = 2'd1;
                    mode_next  = tesp_pkg::MODE_TEXT;
                    seq_next   = tesp_pkg::SEQ_NONE;
                    phase_next = 1'b0;
                    u8_next    = tesp_pkg::U8_ACCEPT;
                    acc_next   = 21'd0;
                end
                else
                begin
                    // held-back byte first, then this one unless it is a second ESC
                    mode_next = tesp_pkg::MODE_STR;
                    r0.value  = (mode_reg == tesp_pkg::MODE_STR_ESC) ?
                                {13'd0, tesp_pkg::B_ESC} : {13'd0, tesp_pkg::B_C2};
                    r1.kind   = tesp_pkg::KIND_PAYLOAD;
                    r1.value  = {13'd0, b};
                    cnt = (mode_reg == tesp_pkg::MODE_STR_ESC && b == tesp_pkg::B_ESC) ?
                          2'd1 : 2'd2;
                end
            end
            default:
            begin
                if (mode_reg == tesp_pkg::MODE_ESC && b == tesp_pkg::B_ESC_DCS)
                begin
                    mode_next = tesp_pkg::MODE_STR;
                    seq_next  = tesp_pkg::SEQ_DCS;
                end
                else if (mode_reg == tesp_pkg::MODE_ESC && b == tesp_pkg::B_ESC_CSI)
                begin
                    mode_next = tesp_pkg::MODE_CSI;
                    seq_next  = tesp_pkg::SEQ_CSI;
                end
                else if (mode_reg == tesp_pkg::MODE_ESC && b == tesp_pkg::B_ESC_OSC)
                begin
                    mode_next = tesp_pkg::MODE_STR_BEL;
                    seq_next  = tesp_pkg::SEQ_OSC;
                end
                else if (mode_reg == tesp_pkg::MODE_ESC && b == tesp_pkg::B_ESC_PM)
                begin
                    mode_next = tesp_pkg::MODE_STR;
                    seq_next  = tesp_pkg::SEQ_PM;
                end
                else if (mode_reg == tesp_pkg::MODE_ESC && b == tesp_pkg::B_ESC_APC)
                begin
                    mode_next = tesp_pkg::MODE_STR;
                    seq_next  = tesp_pkg::SEQ_APC;
                end
                else
                begin
                    // text decode; a stray ESC clears sequence state first
                    mode_next = tesp_pkg::MODE_TEXT;
                    if (mode_reg == tesp_pkg::MODE_ESC)
                    begin
                        seq_next   = tesp_pkg::SEQ_NONE;
                        phase_next = 1'b0;
                    end
                    u8_next  = tx_st;
                    acc_next = tx_acc;
                    if (tx_st == tesp_pkg::U8_ACCEPT && s1.st != tesp_pkg::U8_REJECT ||
                        tx_st == tesp_pkg::U8_ACCEPT && tx_st0 != tesp_pkg::U8_ACCEPT &&
                        s2.st == tesp_pkg::U8_ACCEPT)
                    begin
                        case (tx_acc)
                            tesp_pkg::CP_ESC: mode_next = tesp_pkg::MODE_ESC;
                            tesp_pkg::CP_DCS:
                            begin
                                mode_next = tesp_pkg::MODE_STR;
                                seq_next  = tesp_pkg::SEQ_DCS;
                            end
                            tesp_pkg::CP_CSI:
                            begin
                                mode_next = tesp_pkg::MODE_CSI;
                                seq_next  = tesp_pkg::SEQ_CSI;
                            end
                            tesp_pkg::CP_OSC:
                            begin
                                mode_next = tesp_pkg::MODE_STR_BEL;
                                seq_next  = tesp_pkg::SEQ_OSC;
                            end
                            tesp_pkg::CP_SOS:
                            begin
                                mode_next = tesp_pkg::MODE_STR;
                                seq_next  = tesp_pkg::SEQ_SOS;
                            end
                            tesp_pkg::CP_PM:
                            begin
                                mode_next = tesp_pkg::MODE_STR;
                                seq_next  = tesp_pkg::SEQ_PM;
                            end
                            tesp_pkg::CP_APC:
                            begin
                                mode_next = tesp_pkg::MODE_STR;
                                seq_next  = tesp_pkg::SEQ_APC;
                            end
                            default:
                            begin
                                r0.kind     = tesp_pkg::KIND_TEXT;
                                r0.value    = tx_acc;
                                r0.seq_type = tesp_pkg::SEQ_NONE;
                                cnt         = 2'd1;
                            end
                        endcase
                    end
                end
            end
        endcase
    end

    assign push          = take && cnt != 2'd0;
    assign push_data.r0  = r0;
    assign push_data.r1  = r1;
    assign push_data.two = cnt == 2'd2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= tesp_pkg::MODE_TEXT;
            seq_reg   <= tesp_pkg::SEQ_NONE;
            phase_reg <= 1'b0;
            u8_reg    <= tesp_pkg::U8_ACCEPT;
            acc_reg   <= 21'd0;
        end
        else if (take)
        begin
            mode_reg  <= mode_next;
            seq_reg   <= seq_next;
            phase_reg <= phase_next;
            u8_reg    <= u8_next;
            acc_reg   <= acc_next;
        end
    end

endmodule

// ===== hdl/tesp_queue.sv =====
// Small FIFO of per-byte result entries.
module tesp_queue #(
    parameter int DEPTH = tesp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tesp_pkg::entry_t    push_data,
    input  logic                pop,
    output tesp_pkg::entry_t    pop_data,
    output tesp_pkg::q_status_t q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    tesp_pkg::entry_t store_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign pop_data     = store_reg[rd_reg];
    assign q_stat.full  = cnt_reg == FULL_CNT;
    assign q_stat.empty = cnt_reg == '0;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = (wr_reg == LAST_PTR) ? '0 : wr_reg + 1'b1;
        if (pop)
            rd_next = (rd_reg == LAST_PTR) ? '0 : rd_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== hdl/tesp_back.sv =====
// Result issue: splits two-result entries, drives the output register.
module tesp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  tesp_pkg::q_status_t q_stat,
    input  tesp_pkg::entry_t    pop_data,
    output logic                pop,
    tesp_res_if.source          res_ch
);

    logic           out_valid_reg, out_valid_next;
    logic           out_last_reg, out_last_next;
    tesp_pkg::res_t out_reg, out_next;
    logic           pend_reg, pend_next;
    tesp_pkg::res_t pend_res_reg, pend_res_next;
    logic           load;

    assign load = !out_valid_reg || res_ch.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_last_next  = out_last_reg;
        out_next       = out_reg;
        pend_next      = pend_reg;
        pend_res_next  = pend_res_reg;
        pop            = 1'b0;
        if (load)
        begin
            if (pend_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = pend_res_reg;
                out_last_next  = 1'b1;
                pend_next      = 1'b0;
            end
            else if (!q_stat.empty)
            begin
                pop            = 1'b1;
                out_valid_next = 1'b1;
                out_next       = pop_data.r0;
                out_last_next  = !pop_data.two;
                pend_next      = pop_data.two;
                pend_res_next  = pop_data.r1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
        pend_res_reg <= pend_res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    assign res_ch.valid    = out_valid_reg;
    assign res_ch.kind     = out_reg.kind;
    assign res_ch.value    = out_reg.value;
    assign res_ch.seq_type = out_reg.seq_type;
    assign res_ch.last     = out_last_reg;

endmodule

// ===== verif/terminal_escape_sequence_parser_top_tb.sv =====
module terminal_escape_sequence_parser_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tesp_pkg::*;

    // Run shape. The byte counts include the directed bytes.
    localparam int PHASE_A_END  = 500;   // random traffic with idling on both sides
    localparam int HOLD_BYTES   = 60;    // bytes sent in the phase with the receiver hold-off
    localparam int TOTAL_BYTES  = 950;   // last stretch runs without idling
    localparam int HOLD_CYCLES  = 300;   // receiver hold-off, long enough to fill the queue
    localparam int QUIET_LIMIT  = 2000;  // cycles without any transfer before giving up
    localparam int SETTLE_TICKS = 8;     // idle ticks after the last owed result

    // One result as it leaves res_ch.
    typedef struct packed {
        logic [1:0]  kind;
        logic [20:0] value;
        logic [2:0]  seq_type;
        logic        last;
    } parsed_t;

    // UTF-8 decoder transitions: rows are decoder states, columns byte classes.
    localparam logic [3:0] UTF8_TRANS [0:8][0:11] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1, 4'd1, 4'd1, 4'd4, 4'd6},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1},
        '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
        '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
        '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}
    };

    // Directed opening: ASCII extremes, the largest codepoint, stray and broken
    // UTF-8, ESC with a non-introducer, a CSI through C1 with intermediate,
    // misplaced parameter and control byte, an empty OSC ended by BEL, and an
    // APC carrying ESC ESC and C2 41 before C2 9C closes it.
    localparam logic [7:0] SPECIAL_BYTES [0:28] = '{
        8'h00, 8'h7F,
        8'hF4, 8'h8F, 8'hBF, 8'hBF,
        8'h80, 8'hC3, 8'h41, 8'hFF,
        8'h1B, 8'h58,
        8'hC2, 8'h9B, 8'h20, 8'h31, 8'h0A, 8'h6D,
        8'h1B, 8'h5D, 8'h07,
        8'hC2, 8'h9F, 8'h1B, 8'h1B, 8'hC2, 8'h41, 8'hC2, 8'h9C
    };

    // Parser predictor plus the store of results still owed by the block.
    class parser_chk;
        parsed_t     owed_results[$];
        parsed_t     byte_results[$];
        int          errors      = 0;
        logic [2:0]  mode        = MODE_TEXT;
        logic [2:0]  seq         = SEQ_NONE;
        logic        after_inter = 1'b0;
        logic [3:0]  u8_state    = U8_ACCEPT;
        logic [20:0] acc         = '0;

        function int pending();
            return owed_results.size();
        endfunction

        // at most two results per byte, extras are dropped
        function void push(logic [1:0] k, logic [20:0] v, logic [2:0] s);
            parsed_t r;
            if (byte_results.size() < 2)
            begin
                r.kind     = k;
                r.value    = v;
                r.seq_type = s;
                r.last     = 1'b0;
                byte_results.push_back(r);
            end
        endfunction

        function void back_to_text();
            mode        = MODE_TEXT;
            seq         = SEQ_NONE;
            after_inter = 1'b0;
            u8_state    = U8_ACCEPT;
            acc         = '0;
        endfunction

        function void open_seq(logic [2:0] m, logic [2:0] s);
            mode = m;
            seq  = s;
        endfunction

        function void end_sequence();
            push(KIND_END, '0, seq);
            back_to_text();
        endfunction

        function int char_class(logic [7:0] b);
            if (b == 8'hE0) return 10;
            if (b == 8'hED) return 4;
            if (b == 8'hF0) return 11;
            if (b == 8'hF4) return 5;
            if (b < 8'h80) return 0;
            if (b < 8'h90) return 1;
            if (b < 8'hA0) return 9;
            if (b < 8'hC0) return 7;
            if (b < 8'hC2) return 8;
            if (b < 8'hE0) return 2;
            if (b < 8'hF0) return 3;
            if (b < 8'hF4) return 6;
            return 8;
        endfunction

        // A reject mid-sequence decodes the byte once more from accept.
        function void decode_text(logic [7:0] b);
            logic [3:0] prior;
            logic [3:0] st;
            int         cls;
            prior = u8_state;
            for (int pass = 0; pass < 2; pass++)
            begin
                cls = char_class(b);
                st  = (prior < U8_STATES) ? prior : U8_REJECT;
                if (st == U8_ACCEPT)
                    acc = {13'd0, (8'hFF >> cls) & b};
                else
                    acc = {acc[14:0], b[5:0]};
                u8_state = UTF8_TRANS[st][cls];
                if (u8_state == U8_REJECT)
                begin
                    u8_state = U8_ACCEPT;
                    acc      = '0;
                    if (prior == U8_ACCEPT)
                        return;
                    prior = U8_ACCEPT;
                end
                else
                begin
                    if (u8_state == U8_ACCEPT)
                    begin
                        case (acc)
                            CP_ESC: mode = MODE_ESC;
                            CP_DCS: open_seq(MODE_STR, SEQ_DCS);
                            CP_CSI: open_seq(MODE_CSI, SEQ_CSI);
                            CP_OSC: open_seq(MODE_STR_BEL, SEQ_OSC);
                            CP_SOS: open_seq(MODE_STR, SEQ_SOS);
                            CP_PM:  open_seq(MODE_STR, SEQ_PM);
                            CP_APC: open_seq(MODE_STR, SEQ_APC);
                            default: push(KIND_TEXT, acc, SEQ_NONE);
                        endcase
                    end
                    return;
                end
            end
        endfunction

        function void csi_byte(logic [7:0] b);
            logic is_param;
            logic is_final;
            logic is_inter;
            is_param = (b >= 8'h30 && b <= 8'h3F) || b == B_DASH;
            is_final = !is_param && b >= 8'h40 && b <= 8'h7E;
            is_inter = !is_param && b >= 8'h20 && b <= 8'h2F;
            push(KIND_PAYLOAD, {13'd0, b}, seq);
            if (is_final)
            begin
                end_sequence();
                return;
            end
            if (!after_inter)
            begin
                if (is_inter)
                    after_inter = 1'b1;
                else if (!is_param)
                    push(KIND_MALFORMED, '0, seq);
            end
            else if (!is_inter)
                push(KIND_MALFORMED, '0, seq);
        endfunction

        function void string_byte(logic [7:0] b);
            if (b == B_ESC)
                mode = MODE_STR_ESC;
            else if (b == B_C2)
                mode = MODE_STR_C2;
            else
                push(KIND_PAYLOAD, {13'd0, b}, seq);
        endfunction

        // accepted input byte: work out what it owes
        function void note_byte(logic [7:0] b);
            parsed_t r;
            byte_results.delete();
            case (mode)
                MODE_ESC:
                begin
                    case (b)
                        B_ESC_DCS: open_seq(MODE_STR, SEQ_DCS);
                        B_ESC_CSI: open_seq(MODE_CSI, SEQ_CSI);
                        B_ESC_OSC: open_seq(MODE_STR_BEL, SEQ_OSC);
                        B_ESC_PM:  open_seq(MODE_STR, SEQ_PM);
                        B_ESC_APC: open_seq(MODE_STR, SEQ_APC);
                        default:
                        begin
                            back_to_text();
                            decode_text(b);
                        end
                    endcase
                end
                MODE_CSI: csi_byte(b);
                MODE_STR_BEL:
                begin
                    if (b == B_BEL)
                        end_sequence();
                    else
                        string_byte(b);
                end
                MODE_STR: string_byte(b);
                MODE_STR_ESC:
                begin
                    if (b == B_BSLASH)
                        end_sequence();
                    else
                    begin
                        mode = MODE_STR;
                        push(KIND_PAYLOAD, {13'd0, B_ESC}, seq);
                        if (b != B_ESC)
                            push(KIND_PAYLOAD, {13'd0, b}, seq);
                    end
                end
                MODE_STR_C2:
                begin
                    if (b == B_C1_ST)
                        end_sequence();
                    else
                    begin
                        mode = MODE_STR;
                        push(KIND_PAYLOAD, {13'd0, B_C2}, seq);
                        push(KIND_PAYLOAD, {13'd0, b}, seq);
                    end
                end
                default:
                begin
                    mode = MODE_TEXT;
                    decode_text(b);
                end
            endcase
            foreach (byte_results[i])
            begin
                r      = byte_results[i];
                r.last = (i == byte_results.size() - 1);
                owed_results.push_back(r);
            end
        endfunction

        function void check_result(parsed_t got);
            parsed_t want;
            if (owed_results.size() == 0)
            begin
                $error("unexpected result: kind %0d value 0x%0h seq_type %0d last %0d",
                       got.kind, got.value, got.seq_type, got.last);
                errors++;
                return;
            end
            want = owed_results.pop_front();
            if (got.kind !== want.kind)
            begin
                $error("kind: expected %0d, got %0d", want.kind, got.kind);
                errors++;
            end
            if (got.value !== want.value)
            begin
                $error("value: expected 0x%0h, got 0x%0h", want.value, got.value);
                errors++;
            end
            if (got.seq_type !== want.seq_type)
            begin
                $error("seq_type: expected %0d, got %0d", want.seq_type, got.seq_type);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       idle_on;     // random gaps on both channels
    logic       hold_req;    // asks the receiver for one long hold-off
    int         sent;        // bytes transferred so far
    int         quiet_cycles;
    int         hold_start;
    parser_chk  chk = new;

    tesp_byte_if byte_if ();
    tesp_res_if  res_if ();

    terminal_escape_sequence_parser_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (byte_if),
        .res_ch  (res_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Monitor: both channels sampled at the rising edge. A byte is noted
    // before any result of the same edge is checked; the queue and output
    // register keep a byte's own results at a later edge anyway.
    always @(posedge clk)
    begin
        if (rst_n && byte_if.valid && byte_if.ready)
            chk.note_byte(byte_if.byte_in);
        if (rst_n && res_if.valid && res_if.ready)
            chk.check_result({res_if.kind, res_if.value, res_if.seq_type, res_if.last});
    end

    // Watchdog: a run that goes quiet for too long is a hang.
    always @(posedge clk)
    begin
        if (!rst_n || (byte_if.valid && byte_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Receiver: ready changes on the falling edge. Random stalls while idling
    // is on; one long hold-off on request, counted here.
    initial
    begin
        logic held;
        held         = 1'b0;
        res_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !held)
            begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                held = 1'b1;
                res_if.ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
                res_if.ready <= 1'b1;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    // One byte transfer. Called on a falling edge, returns on the falling edge
    // after the transfer, so valid stays high across back-to-back bytes.
    task automatic send_byte(logic [7:0] b);
        if (idle_on && $urandom_range(0, 11) == 0)
        begin
            byte_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        byte_if.valid   <= 1'b1;
        byte_if.byte_in <= b;
        @(posedge clk);
        while (!byte_if.ready)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    // Sender pause: nothing offered until every owed result has come out.
    task automatic drain();
        byte_if.valid <= 1'b0;
        while (chk.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_TICKS) @(negedge clk);
    endtask

    task automatic send_codepoint(int unsigned cp);
        if (cp < 'h80)
            send_byte(cp[7:0]);
        else if (cp < 'h800)
        begin
            send_byte({3'b110, cp[10:6]});
            send_byte({2'b10, cp[5:0]});
        end
        else if (cp < 'h10000)
        begin
            send_byte({4'b1110, cp[15:12]});
            send_byte({2'b10, cp[11:6]});
            send_byte({2'b10, cp[5:0]});
        end
        else
        begin
            send_byte({5'b11110, cp[20:18]});
            send_byte({2'b10, cp[17:12]});
            send_byte({2'b10, cp[11:6]});
            send_byte({2'b10, cp[5:0]});
        end
    endtask

    // Introducer in ESC form or as a UTF-8 encoded C1 (C2 xx).
    task automatic send_intro(logic has_esc_form, logic [7:0] esc_final, logic [7:0] c1);
        if (has_esc_form && $urandom_range(0, 1) == 1)
        begin
            send_byte(B_ESC);
            send_byte(esc_final);
        end
        else
        begin
            send_byte(B_C2);
            send_byte(c1);
        end
    endtask

    // Short text run: mostly well-formed UTF-8, C1 codepoints included,
    // now and then a lead byte cut short.
    task automatic send_text();
        int          n;
        int unsigned cp;
        n = $urandom_range(1, 8);
        repeat (n)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: send_byte(8'($urandom_range(8'h20, 8'h7E)));
                5:             send_byte(8'($urandom_range(8'h00, 8'h1F)));
                6:             send_codepoint($urandom_range('h80, 'h7FF));
                7:
                begin
                    cp = $urandom_range('h800, 'hFFFF);
                    if (cp >= 'hD800 && cp <= 'hDFFF)
                        cp = cp - 'h1000;
                    send_codepoint(cp);
                end
                8:             send_codepoint($urandom_range('h10000, 'h10FFFF));
                default:       send_byte(8'($urandom_range(8'hC2, 8'hF4)));
            endcase
        end
    endtask

    // CSI: parameters, optional intermediates, final; occasionally a stray byte.
    task automatic send_csi();
        int n;
        send_intro(1'b1, B_ESC_CSI, CP_CSI[7:0]);
        n = $urandom_range(0, 6);
        repeat (n)
        begin
            if ($urandom_range(0, 9) == 0)
                send_byte(B_DASH);
            else
                send_byte(8'($urandom_range(8'h30, 8'h3F)));
        end
        if ($urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 2);
            repeat (n) send_byte(8'($urandom_range(8'h20, 8'h2F)));
        end
        if ($urandom_range(0, 7) == 0)
            send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(8'h40, 8'h7E)));
    endtask

    // String sequence of any type, random payload, any terminator or none.
    task automatic send_string();
        int n;
        int term;
        case ($urandom_range(0, 4))
            0:       send_intro(1'b1, B_ESC_OSC, CP_OSC[7:0]);
            1:       send_intro(1'b1, B_ESC_DCS, CP_DCS[7:0]);
            2:       send_intro(1'b1, B_ESC_PM, CP_PM[7:0]);
            3:       send_intro(1'b1, B_ESC_APC, CP_APC[7:0]);
            default: send_intro(1'b0, B_ESC, CP_SOS[7:0]);
        endcase
        n = $urandom_range(0, 12);
        repeat (n)
        begin
            if ($urandom_range(0, 5) == 0)
                send_byte(8'($urandom_range(0, 255)));
            else
                send_byte(8'($urandom_range(8'h20, 8'h7E)));
        end
        term = $urandom_range(0, 9);
        if (term < 3)
            send_byte(B_BEL);
        else if (term < 6)
        begin
            send_byte(B_ESC);
            send_byte(B_BSLASH);
        end
        else if (term < 9)
        begin
            send_byte(B_C2);
            send_byte(B_C1_ST);
        end
        // else left open; whatever follows lands inside the sequence
    endtask

    task automatic send_noise();
        int n;
        if ($urandom_range(0, 2) == 0)
        begin
            send_byte(B_ESC);
            send_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            n = $urandom_range(1, 4);
            repeat (n) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_chunk();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 8)
            send_text();
        else if (pick < 12)
            send_csi();
        else if (pick < 17)
            send_string();
        else
            send_noise();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        byte_if.valid   = 1'b0;
        byte_if.byte_in = '0;
        idle_on         = 1'b0;
        hold_req        = 1'b0;
        sent            = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < $size(SPECIAL_BYTES); i++)
            send_byte(SPECIAL_BYTES[i]);
        drain();

        // random sequences, text and noise, gaps on both sides
        idle_on = 1'b1;
        while (sent < PHASE_A_END)
            send_chunk();
        drain();

        // receiver holds off while CSI bytes keep coming: the queue fills
        // and byte_ch.ready has to drop
        idle_on    = 1'b0;
        hold_req   = 1'b1;
        hold_start = sent;
        while (sent < hold_start + HOLD_BYTES)
            send_csi();
        drain();

        // closing stretch at full rate
        while (sent < TOTAL_BYTES)
            send_chunk();
        drain();

        if (chk.errors == 0 && chk.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
